>>> hw/rtl/pn3d_pkg.sv
// Shared constants for the 3D gradient noise pipeline.
package pn3d_pkg;
   localparam logic [31:0] HASH_MUL = 32'h045d9f3b;
   localparam int CORNERS = 8;
endpackage

>>> hw/rtl/perlin_noise_3d.sv
// Top level: 3D gradient noise, fully pipelined, one point per beat.
// Throughput: one point per cycle; busy is tied low, nothing stalls.
// Depth: input register, eight hash stages (xor, multiply per step), gradient stage,
// x and y lerps in three stages each, z lerp in two plus the add and clamp register.
// Reset (synchronous, active high) clears all valid bits; payload is not reset.
module perlin_noise_3d #(
   parameter int FRAC_BITS = 16,
   parameter int INT_BITS  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [INT_BITS+FRAC_BITS-1:0] req_coord_x,
   input  logic signed [INT_BITS+FRAC_BITS-1:0] req_coord_y,
   input  logic signed [INT_BITS+FRAC_BITS-1:0] req_coord_z,
   input  logic signed [31:0]             req_noise_seed,
   output logic                           rsp_valid,
   output logic signed [FRAC_BITS+2:0]    rsp_noise_value
);
   import pn3d_pkg::*;

   localparam int CW   = INT_BITS + FRAC_BITS;
   localparam int FW   = FRAC_BITS;
   localparam int VW   = FW + 6;              // wide signed work value
   localparam int OW   = FW + 3;
   localparam int DEPTH = 19;
   localparam logic signed [VW-1:0] ONE = VW'(1) <<< FW;
   localparam logic signed [VW-1:0] LIM = VW'(2) <<< FW;

   // Truncated Q product, floor semantics
   function automatic logic signed [VW-1:0] qmul(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b);
      logic signed [2*VW-1:0] p;
      p = a * b;
      return VW'(p >>> FW);
   endfunction

   function automatic logic signed [VW-1:0] grad(input logic [3:0] g,
      input logic signed [VW-1:0] x, input logic signed [VW-1:0] y,
      input logic signed [VW-1:0] z);
      logic signed [VW-1:0] p, q;
      p = (g < 4'd8) ? x : y;
      q = (g < 4'd4) ? y : ((g == 4'd12 || g == 4'd14) ? x : z);
      if (g[0]) p = -p;
      if (g[1]) q = -q;
      return p + q;
   endfunction

   assign busy = 1'b0;

   // valid shift line
   logic [DEPTH-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[DEPTH-2:0], start};
   end

   // stage 1: cell indices and fractions
   logic [31:0]            c0_ff [3];
   logic signed [VW-1:0]   f_ff  [9][3];
   logic [31:0]            seed_ff;
   logic signed [CW-1:0]   crd [3];
   assign crd[0] = req_coord_x;
   assign crd[1] = req_coord_y;
   assign crd[2] = req_coord_z;

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         c0_ff[a]   <= 32'(signed'(crd[a] >>> FW));
         f_ff[0][a] <= VW'({1'b0, crd[a][FW-1:0]});
      end
      seed_ff <= req_noise_seed;
      for (int s = 1; s < 9; s++) f_ff[s] <= f_ff[s-1];
   end

   // hash pipeline: xor then multiply, one register per step (stages 2..9)
   logic [31:0] hx_ff [CORNERS], hm1_ff [CORNERS], hy_ff [CORNERS], hm2_ff [CORNERS];
   logic [31:0] hz_ff [CORNERS], hm3_ff [CORNERS], ha_ff [CORNERS], hm4_ff [CORNERS];
   logic [31:0] cy_ff [2][3], cz_ff [2][3];
   always_ff @(posedge clock) begin
      cy_ff[0] <= c0_ff; cy_ff[1] <= cy_ff[0];
      cz_ff[0] <= cy_ff[1]; cz_ff[1] <= cz_ff[0];
      for (int k = 0; k < CORNERS; k++) begin
         hx_ff[k]  <= seed_ff ^ (c0_ff[0] + 32'(k[0]));
         hm1_ff[k] <= hx_ff[k] * HASH_MUL;
         hy_ff[k]  <= hm1_ff[k] ^ (cy_ff[1][1] + 32'(k[1]));
         hm2_ff[k] <= hy_ff[k] * HASH_MUL;
         hz_ff[k]  <= hm2_ff[k] ^ (cz_ff[1][2] + 32'(k[2]));
         hm3_ff[k] <= hz_ff[k] * HASH_MUL;
         ha_ff[k]  <= hm3_ff[k] ^ 32'(signed'(hm3_ff[k]) >>> 16);
         hm4_ff[k] <= ha_ff[k] * HASH_MUL;
      end
   end
   // hm4 valid at stage 9 (f_ff[8] aligned)

   // gradients, stage 10
   logic signed [VW-1:0] g_ff [CORNERS];
   always_ff @(posedge clock) begin
      for (int k = 0; k < CORNERS; k++)
         g_ff[k] <= grad(hm4_ff[k][3:0],
                         k[0] ? f_ff[8][0] - ONE : f_ff[8][0],
                         k[1] ? f_ff[8][1] - ONE : f_ff[8][1],
                         k[2] ? f_ff[8][2] - ONE : f_ff[8][2]);
   end

   // fade chain from f_ff[0], stages 1..4, then delayed
   logic signed [VW-1:0] fa_ff [3], tt_ff [3], fb_ff [3], ttt_ff [3];
   logic signed [VW-1:0] fu_ff [3], fd_ff [7][3];
   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         fa_ff[a]  <= VW'(f_ff[0][a] * 6) - (VW'(15) <<< FW);
         tt_ff[a]  <= qmul(f_ff[0][a], f_ff[0][a]);
         fb_ff[a]  <= qmul(f_ff[1][a], fa_ff[a]) + (VW'(10) <<< FW);
         ttt_ff[a] <= qmul(tt_ff[a], f_ff[1][a]);
         fu_ff[a]  <= qmul(ttt_ff[a], fb_ff[a]);
      end
      fd_ff[0] <= fu_ff;
      for (int s = 1; s < 7; s++) fd_ff[s] <= fd_ff[s-1];
   end
   // fu at stage 4; fd_ff[6] is stage 11, read by the x product stage

   // lerp x: diff (11), product (12), add (13)
   logic signed [VW-1:0] dx_ff [4], ax_ff [4], px_ff [4], ax2_ff [4], lx_ff [4];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         dx_ff[i]  <= g_ff[2*i+1] - g_ff[2*i];
         ax_ff[i]  <= g_ff[2*i];
         px_ff[i]  <= qmul(fd_ff[6][0], dx_ff[i]);
         ax2_ff[i] <= ax_ff[i];
         lx_ff[i]  <= ax2_ff[i] + px_ff[i];
      end
   end
   // y/z weights delayed from fd_ff[6] to their product stages
   logic signed [VW-1:0] vy [3], wz [6];
   always_ff @(posedge clock) begin
      vy[0] <= fd_ff[6][1]; wz[0] <= fd_ff[6][2];
      for (int s = 1; s < 3; s++) vy[s] <= vy[s-1];
      for (int s = 1; s < 6; s++) wz[s] <= wz[s-1];
   end

   // lerp y: diff (14), product (15), add (16)
   logic signed [VW-1:0] dy_ff [2], ay_ff [2], py_ff [2], ay2_ff [2], ly_ff [2];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         dy_ff[i]  <= lx_ff[2*i+1] - lx_ff[2*i];
         ay_ff[i]  <= lx_ff[2*i];
         py_ff[i]  <= qmul(vy[2], dy_ff[i]);
         ay2_ff[i] <= ay_ff[i];
         ly_ff[i]  <= ay2_ff[i] + py_ff[i];
      end
   end

   // lerp z: diff (17), product (18), add+clamp into output
   logic signed [VW-1:0] dz_ff, az_ff, pz_ff, az2_ff, r;
   logic signed [OW-1:0] out_ff;
   always_ff @(posedge clock) begin
      dz_ff  <= ly_ff[1] - ly_ff[0];
      az_ff  <= ly_ff[0];
      pz_ff  <= qmul(wz[5], dz_ff);
      az2_ff <= az_ff;
   end
   always_comb begin
      r = az2_ff + pz_ff;
      if (r > LIM)  r = LIM;
      if (r < -LIM) r = -LIM;
   end
   always_ff @(posedge clock) out_ff <= OW'(r);

   assign rsp_valid       = vld_ff[DEPTH-1];
   assign rsp_noise_value = out_ff;
endmodule

>>> hw/rtl/pn3d_checker.sv
// Port-level checker for the noise pipeline, bound to the top level.
module pn3d_props #(
   parameter int FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic signed [FRAC_BITS+2:0] rsp_noise_value
);
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##19 rsp_valid) else $error("result missing");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 19)) else $error("result invented");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_noise_value <= (1 <<< (FRAC_BITS+1)) &&
                     rsp_noise_value >= -(1 <<< (FRAC_BITS+1))))
      else $error("out of range");
endmodule

bind perlin_noise_3d pn3d_props #(.FRAC_BITS(FRAC_BITS)) u_pn3d_props (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_noise_value(rsp_noise_value));
